// ===== rtl/knn_majority_vote_core_defines.svh =====
// Assertion helpers for the vote core checker.
`ifndef KNN_MAJORITY_VOTE_CORE_DEFINES_SVH
`define KNN_MAJORITY_VOTE_CORE_DEFINES_SVH

// Check on every edge outside reset.
`define KMV_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("kmv check failed");

// Check on every edge, reset included.
`define KMV_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge clk) prop) else $error("kmv check failed in reset");

`endif

// ===== rtl/kmv_pkg.sv =====
`default_nettype none
package kmv_pkg;

    localparam logic [1:0] CFG_NEIGHBOURS_K = 2'd0;
    localparam logic [1:0] CFG_VOTE_MODE    = 2'd1;
    localparam logic [1:0] CFG_CLASS_COUNT  = 2'd2;

    localparam logic [1:0] VM_CLASS = 2'd0;
    localparam logic [1:0] VM_GROUP = 2'd1;
    localparam logic [1:0] VM_VOICE = 2'd2;

    localparam logic [6:0] K_RESET     = 7'd3;
    localparam logic [6:0] CLASS_RESET = 7'd40;

    typedef struct packed {
        logic [31:0] distance;
        logic [5:0]  label;
        logic        last;
    } kmv_in_t;

    typedef struct packed {
        logic [5:0] winner;
        logic [6:0] winner_votes;
    } kmv_out_t;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_CLEAR,
        ST_FETCH,
        ST_CAPT,
        ST_SCAN,
        ST_VRD,
        ST_VWR,
        ST_PICK,
        ST_OUT
    } kmv_state_t;

    typedef struct packed {
        logic ready;
        logic clr;
        logic fetch;
        logic capt;
        logic scan;
        logic vrd;
        logic vwr;
        logic pick_init;
        logic pick;
        logic out_load;
    } kmv_cmd_t;

    typedef struct packed {
        logic clr_end;
        logic scan_end;
        logic i_last;
        logic pick_end;
        logic out_free;
    } kmv_status_t;

    function automatic logic [5:0] group_of(input logic [5:0] lab);
        logic [5:0] g;
        if (lab >= 6'd1 && lab <= 6'd6)        g = 6'd0;
        else if (lab >= 6'd7 && lab <= 6'd8)   g = 6'd1;
        else if (lab >= 6'd9 && lab <= 6'd15)  g = 6'd2;
        else if (lab >= 6'd16 && lab <= 6'd18) g = 6'd3;
        else if (lab >= 6'd19 && lab <= 6'd23) g = 6'd4;
        else if (lab >= 6'd24 && lab <= 6'd37) g = 6'd5;
        else                                   g = 6'd6;
        return g;
    endfunction

    function automatic logic [5:0] voice_of(input logic [5:0] lab);
        logic [5:0] v;
        if (lab >= 6'd1 && lab <= 6'd15)       v = 6'd0;
        else if (lab >= 6'd16 && lab <= 6'd37) v = 6'd1;
        else                                   v = 6'd2;
        return v;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/kmv_ctrl.sv =====
`default_nettype none
module kmv_ctrl
    import kmv_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    input  wire logic        in_last,
    input  wire kmv_status_t st,
    output kmv_cmd_t         cmd
);

    kmv_state_t state_reg;
    kmv_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_LOAD:  if (in_valid && in_last) state_next = ST_CLEAR;
            ST_CLEAR: if (st.clr_end) state_next = ST_FETCH;
            ST_FETCH: state_next = ST_CAPT;
            ST_CAPT:  state_next = ST_SCAN;
            ST_SCAN:  if (st.scan_end) state_next = ST_VRD;
            ST_VRD:   state_next = ST_VWR;
            ST_VWR:   state_next = st.i_last ? ST_PICK : ST_FETCH;
            ST_PICK:  if (st.pick_end) state_next = ST_OUT;
            ST_OUT:   if (st.out_free) state_next = ST_LOAD;
            default:  state_next = ST_LOAD;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        unique case (state_reg)
            ST_LOAD:  cmd.ready = 1'b1;
            ST_CLEAR: cmd.clr = 1'b1;
            ST_FETCH: cmd.fetch = 1'b1;
            ST_CAPT:  cmd.capt = 1'b1;
            ST_SCAN:  cmd.scan = 1'b1;
            ST_VRD:   cmd.vrd = 1'b1;
            ST_VWR:
            begin
                cmd.vwr       = 1'b1;
                cmd.pick_init = st.i_last;
            end
            ST_PICK:  cmd.pick = 1'b1;
            ST_OUT:   cmd.out_load = st.out_free;
            default:  cmd = '0;
        endcase
    end

endmodule
`default_nettype wire

// ===== rtl/kmv_datapath.sv =====
`default_nettype none
module kmv_datapath
    import kmv_pkg::*;
#(
    parameter int MAX_CANDIDATES = 64,
    parameter int MAX_CLASSES    = 64,
    parameter int DIST_WIDTH     = 32
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire kmv_cmd_t cmd,
    input  wire logic     in_valid,
    input  wire kmv_in_t  in_data,
    input  wire logic     out_stall,
    input  wire logic [6:0] cfg_k,
    input  wire logic [1:0] cfg_mode,
    input  wire logic [6:0] cfg_classes,
    output kmv_status_t   st,
    output logic          out_valid,
    output kmv_out_t      out_data
);

    localparam int CW  = $clog2(MAX_CANDIDATES + 1);
    localparam int AW  = $clog2(MAX_CANDIDATES);
    localparam int VW  = $clog2(MAX_CLASSES);
    localparam int VCW = $clog2(MAX_CLASSES + 1);
    localparam int IW  = (CW > VCW) ? CW : VCW;
    localparam int KW  = (CW > 7) ? CW : 7;
    localparam int DW  = DIST_WIDTH;
    localparam int SH  = CW + 1;
    localparam int RCP = (2 ** SH + 2) / 3;
    localparam int PW  = CW + SH + 2;

    // candidate store and vote bins
    logic [DW+5:0] cand_mem [MAX_CANDIDATES];
    logic [CW-1:0] vote_mem [MAX_CLASSES];

    logic [DW+5:0] cand_q_reg;
    logic [CW-1:0] vote_q_reg;

    logic [CW-1:0] cnt_reg, cnt_next;
    logic [IW-1:0] idx_reg, idx_next;
    logic [CW-1:0] i_reg, i_next;
    logic [CW-1:0] rank_reg, rank_next;
    logic [KW-1:0] k_reg, k_next;
    logic          cmpv_reg, cmpv_next;
    logic [CW-1:0] jd_reg, jd_next;
    logic [DW-1:0] di_reg, di_next;
    logic [5:0]    li_reg, li_next;
    logic          pv_reg, pv_next;
    logic [VW-1:0] pb_reg, pb_next;
    logic [VW-1:0] best_reg, best_next;
    logic [CW-1:0] most_reg, most_next;
    logic          out_valid_reg, out_valid_next;
    kmv_out_t      out_reg, out_next;

    logic          accept;
    logic [63:0]   dist_wide;
    logic [DW-1:0] dist_val;
    logic [15:0]   n16, idx16, hi16, lo16, cnt16;
    logic          issue_scan, issue_pick;
    logic [DW-1:0] dj;
    logic          closer;
    logic [5:0]    bin;
    logic [15:0]   bin16;
    logic          vote_ok;
    logic [AW-1:0] cand_rd_addr;
    logic [VW-1:0] vote_rd_addr;
    logic          vote_we;
    logic [VW-1:0] vote_wr_addr;
    logic [CW-1:0] vote_wr_data;
    logic [PW-1:0] prod;
    logic [KW-1:0] third;
    logic [KW-1:0] k_cfg_w, n_w;
    logic [15:0]   best16, most16;

    assign accept    = cmd.ready && in_valid;
    assign dist_wide = {32'd0, in_data.distance};
    assign dist_val  = dist_wide[DW-1:0];

    assign cnt16 = 16'(cnt_reg);
    assign n16   = cnt16;
    assign idx16 = 16'(idx_reg);

    always_comb
    begin
        case (cfg_mode)
            VM_GROUP:
            begin
                bin  = group_of(li_reg);
                lo16 = 16'd0;
                hi16 = 16'd7;
            end
            VM_VOICE:
            begin
                bin  = voice_of(li_reg);
                lo16 = 16'd0;
                hi16 = 16'd3;
            end
            default:
            begin
                bin  = li_reg;
                lo16 = 16'd1;
                hi16 = (16'(cfg_classes) > 16'(MAX_CLASSES)) ? 16'(MAX_CLASSES)
                                                            : 16'(cfg_classes);
            end
        endcase
    end

    assign bin16   = 16'(bin);
    assign vote_ok = (KW'(rank_reg) < k_reg) && (bin16 < 16'(MAX_CLASSES));

    assign issue_scan = cmd.scan && (idx16 < n16);
    assign issue_pick = cmd.pick && (idx16 < hi16);

    // rank order: smaller distance first, earlier arrival first on a tie
    assign dj     = cand_q_reg[DW-1:0];
    assign closer = (dj < di_reg) || ((dj == di_reg) && (jd_reg < i_reg));

    // k clamp: when k is not below the count, count/3 by reciprocal multiply, at least one
    assign prod    = PW'(cnt_reg) * PW'(RCP);
    assign third   = KW'(prod[SH+CW-1:SH]);
    assign k_cfg_w = KW'(cfg_k);
    assign n_w     = KW'(cnt_reg);

    always_comb
    begin
        if (k_cfg_w >= n_w)
        begin
            k_next = (third == '0) ? KW'(1) : third;
        end
        else
        begin
            k_next = k_cfg_w;
        end
        if (!cmd.clr)
        begin
            k_next = k_reg;
        end
    end

    assign cand_rd_addr = cmd.fetch ? i_reg[AW-1:0] : idx_reg[AW-1:0];
    assign vote_rd_addr = cmd.pick ? idx_reg[VW-1:0] : bin16[VW-1:0];

    always_comb
    begin
        vote_we      = 1'b0;
        vote_wr_addr = idx_reg[VW-1:0];
        vote_wr_data = '0;
        if (cmd.clr)
        begin
            vote_we = 1'b1;
        end
        else if (cmd.vwr && vote_ok)
        begin
            vote_we      = 1'b1;
            vote_wr_addr = bin16[VW-1:0];
            vote_wr_data = CW'(vote_q_reg + 1'b1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && (cnt16 < 16'(MAX_CANDIDATES)))
        begin
            cand_mem[cnt_reg[AW-1:0]] <= {in_data.label, dist_val};
        end
    end

    always_ff @(posedge clk)
    begin
        cand_q_reg <= cand_mem[cand_rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (vote_we)
        begin
            vote_mem[vote_wr_addr] <= vote_wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        vote_q_reg <= vote_mem[vote_rd_addr];
    end

    always_comb
    begin
        cnt_next       = cnt_reg;
        idx_next       = idx_reg;
        i_next         = i_reg;
        rank_next      = rank_reg;
        cmpv_next      = issue_scan;
        jd_next        = idx_reg[CW-1:0];
        di_next        = di_reg;
        li_next        = li_reg;
        pv_next        = issue_pick;
        pb_next        = idx_reg[VW-1:0];
        best_next      = best_reg;
        most_next      = most_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_next       = out_reg;

        if (accept)
        begin
            if (cnt16 < 16'(MAX_CANDIDATES))
            begin
                cnt_next = CW'(cnt_reg + 1'b1);
            end
            if (in_data.last)
            begin
                idx_next = '0;
                i_next   = '0;
            end
        end
        if (cmd.clr)
        begin
            idx_next = IW'(idx_reg + 1'b1);
        end
        if (cmd.capt)
        begin
            di_next   = cand_q_reg[DW-1:0];
            li_next   = cand_q_reg[DW+5:DW];
            idx_next  = '0;
            rank_next = '0;
        end
        if (issue_scan)
        begin
            idx_next = IW'(idx_reg + 1'b1);
        end
        if (cmpv_reg && closer)
        begin
            rank_next = CW'(rank_reg + 1'b1);
        end
        if (cmd.vwr)
        begin
            i_next = CW'(i_reg + 1'b1);
        end
        if (cmd.pick_init)
        begin
            idx_next  = IW'(lo16);
            best_next = '0;
            most_next = '0;
        end
        if (issue_pick)
        begin
            idx_next = IW'(idx_reg + 1'b1);
        end
        // strict compare keeps the lowest bin on a tie
        if (pv_reg && (vote_q_reg > most_reg))
        begin
            most_next = vote_q_reg;
            best_next = pb_reg;
        end
        if (cmd.out_load)
        begin
            out_valid_next        = 1'b1;
            out_next.winner       = best16[5:0];
            out_next.winner_votes = most16[6:0];
            cnt_next              = '0;
        end
    end

    assign best16 = 16'(best_reg);
    assign most16 = 16'(most_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            idx_reg       <= '0;
            i_reg         <= '0;
            rank_reg      <= '0;
            k_reg         <= '0;
            cmpv_reg      <= 1'b0;
            jd_reg        <= '0;
            pv_reg        <= 1'b0;
            pb_reg        <= '0;
            best_reg      <= '0;
            most_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cnt_reg       <= cnt_next;
            idx_reg       <= idx_next;
            i_reg         <= i_next;
            rank_reg      <= rank_next;
            k_reg         <= k_next;
            cmpv_reg      <= cmpv_next;
            jd_reg        <= jd_next;
            pv_reg        <= pv_next;
            pb_reg        <= pb_next;
            best_reg      <= best_next;
            most_reg      <= most_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        di_reg  <= di_next;
        li_reg  <= li_next;
        out_reg <= out_next;
    end

    assign st.clr_end  = (idx16 == 16'(MAX_CLASSES - 1));
    assign st.scan_end = !(idx16 < n16);
    assign st.i_last   = (16'(i_reg) == 16'(n16 - 16'd1));
    assign st.pick_end = !(idx16 < hi16);
    assign st.out_free = !out_valid_reg || !out_stall;

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule
`default_nettype wire

// ===== rtl/knn_majority_vote_core.sv =====
// Channel  | Direction | Handshake           | Payload
// in       | input     | in_valid / in_stall  | in_data   (distance, label, last)
// out      | output    | out_valid / out_stall| out_data  (winner, winner_votes)
// cfg      | input     | cfg_we               | cfg_index, cfg_wdata
//
// Loading accepts one candidate transfer per cycle. After the last candidate the
// block clears the vote bins, ranks every candidate by a full scan of the
// candidate memory through its single read port, then scans the bins for the
// winner. in_stall stays high from the last transfer until the result is
// loaded into the output register. Reset is asynchronous, active low; the
// memories carry no reset and are cleared or written before use.
`default_nettype none
module knn_majority_vote_core
    import kmv_pkg::*;
#(
    parameter int MAX_CANDIDATES = 64,
    parameter int MAX_CLASSES    = 64,
    parameter int DIST_WIDTH     = 32
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire kmv_in_t    in_data,
    output logic            out_valid,
    input  wire logic       out_stall,
    output kmv_out_t        out_data,
    input  wire logic       cfg_we,
    input  wire logic [1:0] cfg_index,
    input  wire logic [6:0] cfg_wdata
);

    kmv_cmd_t    cmd;
    kmv_status_t st;

    logic [6:0] k_reg, k_next;
    logic [1:0] mode_reg, mode_next;
    logic [6:0] classes_reg, classes_next;

    // Register writes; an index past the list is dropped.
    always_comb
    begin
        k_next       = k_reg;
        mode_next    = mode_reg;
        classes_next = classes_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_NEIGHBOURS_K: k_next       = cfg_wdata;
                CFG_VOTE_MODE:    mode_next    = cfg_wdata[1:0];
                CFG_CLASS_COUNT:  classes_next = cfg_wdata;
                default:          k_next       = k_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_reg       <= K_RESET;
            mode_reg    <= VM_CLASS;
            classes_reg <= CLASS_RESET;
        end
        else
        begin
            k_reg       <= k_next;
            mode_reg    <= mode_next;
            classes_reg <= classes_next;
        end
    end

    // Hold off new candidates while a set is being ranked and voted and until its result is loaded.
    assign in_stall = !cmd.ready;

    kmv_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_last  (in_data.last),
        .st       (st),
        .cmd      (cmd)
    );

    kmv_datapath #(
        .MAX_CANDIDATES (MAX_CANDIDATES),
        .MAX_CLASSES    (MAX_CLASSES),
        .DIST_WIDTH     (DIST_WIDTH)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .in_valid    (in_valid),
        .in_data     (in_data),
        .out_stall   (out_stall),
        .cfg_k       (k_reg),
        .cfg_mode    (mode_reg),
        .cfg_classes (classes_reg),
        .st          (st),
        .out_valid   (out_valid),
        .out_data    (out_data)
    );

endmodule
`default_nettype wire

// ===== rtl/kmv_checker.sv =====
`default_nettype none
`include "knn_majority_vote_core_defines.svh"
module kmv_checker
    import kmv_pkg::*;
(
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       in_valid,
    input wire logic       in_stall,
    input wire kmv_in_t    in_data,
    input wire logic       out_valid,
    input wire logic       out_stall,
    input wire kmv_out_t   out_data,
    input wire logic       cfg_we,
    input wire logic [1:0] cfg_index,
    input wire logic [6:0] cfg_wdata
);

    logic unused_cfg;
    assign unused_cfg = cfg_we ^ (^cfg_index) ^ (^cfg_wdata);

    `KMV_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(out_data))
    `KMV_ASSERT(a_busy_after_last, in_valid && !in_stall && in_data.last |=> in_stall)
    `KMV_ASSERT(a_open_mid_set, in_valid && !in_stall && !in_data.last |=> !in_stall)
    `KMV_ASSERT_ALWAYS(a_reset_idle, !rst_n |-> !out_valid)

endmodule

bind knn_majority_vote_core kmv_checker u_kmv_checker (.*);
`default_nettype wire
